[hdl/prpe_pkg.sv]
// Package: shared widths, constants and the per-rank history record.
package prpe_pkg;

  localparam int RANK_FW   = 6;
  localparam int REGION_W  = 64;
  localparam int TIME_W    = 48;
  localparam int PROG_W    = 17;
  localparam int CFG_IDX_W = 1;
  localparam int PROD_W    = PROG_W + TIME_W;
  localparam int INC_W     = PROG_W + 1;

  localparam int NUM_RANKS_DEF = 16;

  localparam logic [PROG_W-1:0] ONE_Q16 = PROG_W'(65536);
  localparam logic [PROG_W-1:0] MAX_Q16 = PROG_W'(65535);
  localparam logic [INC_W-1:0]  INC_MAX = INC_W'(131072);

  localparam logic [CFG_IDX_W-1:0] REG_UNMARKED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EPOCH    = 1'b1;

  localparam logic OP_PROFILE = 1'b0;
  localparam logic OP_ALIGN   = 1'b1;

  typedef struct packed {
    logic [1:0]          cnt;
    logic [TIME_W-1:0]   t_old;
    logic [PROG_W-1:0]   p_old;
    logic [TIME_W-1:0]   t_new;
    logic [PROG_W-1:0]   p_new;
    logic [REGION_W-1:0] region;
  } hist_rec_t;

endpackage

[hdl/prpe_hist.sv]
// History memory: one record per rank, registered read, valid bits for reset.
module prpe_hist #(
  parameter int DEPTH = prpe_pkg::NUM_RANKS_DEF,
  parameter int AW    = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  prpe_pkg::hist_rec_t wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output prpe_pkg::hist_rec_t rdata
);

  prpe_pkg::hist_rec_t mem [DEPTH];
  logic [DEPTH-1:0]    valid_r;
  prpe_pkg::hist_rec_t rdata_r;
  logic                rvld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rvld_r  <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      if (re) begin
        rvld_r <= valid_r[raddr];
      end
    end
  end

  // An entry never written since reset reads as the all-zero record.
  assign rdata = rvld_r ? rdata_r : '0;

endmodule

[hdl/prpe_mul.sv]
// Bit-serial multiplier: one multiplier bit per cycle, LSB first.
module prpe_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [prpe_pkg::PROG_W-1:0]   a,
  input  logic [prpe_pkg::TIME_W-1:0]   b,
  output logic                          done,
  output logic [prpe_pkg::PROD_W-1:0]   prod
);

  localparam int CW = $clog2(prpe_pkg::TIME_W);

  logic                          busy_r;
  logic                          done_r;
  logic [CW-1:0]                 cnt_r;
  logic [prpe_pkg::PROG_W-1:0]   a_r;
  logic [prpe_pkg::PROG_W-1:0]   hi_r;
  logic [prpe_pkg::TIME_W-1:0]   lo_r;
  logic [prpe_pkg::PROG_W:0]     sum;

  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(prpe_pkg::TIME_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (busy_r) begin
      hi_r <= sum[prpe_pkg::PROG_W:1];
      lo_r <= {sum[0], lo_r[prpe_pkg::TIME_W-1:1]};
    end
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};

endmodule

[hdl/prpe_div.sv]
// Bit-serial restoring divider with a quotient saturated at twice full scale.
module prpe_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [prpe_pkg::PROD_W-1:0]   dividend,
  input  logic [prpe_pkg::TIME_W-1:0]   divisor,
  output logic                          done,
  output logic [prpe_pkg::INC_W-1:0]    quo
);

  localparam int CW = $clog2(prpe_pkg::PROD_W);

  logic                          busy_r;
  logic                          done_r;
  logic [CW-1:0]                 cnt_r;
  logic [prpe_pkg::TIME_W-1:0]   dvs_r;
  logic [prpe_pkg::TIME_W-1:0]   rem_r;
  logic [prpe_pkg::PROD_W-1:0]   dvd_r;
  logic [prpe_pkg::INC_W-1:0]    q_r;
  logic                          ovf_r;
  logic [prpe_pkg::TIME_W:0]     sh;
  logic [prpe_pkg::TIME_W+1:0]   diff;
  logic                          ge;

  assign sh   = {rem_r, dvd_r[prpe_pkg::PROD_W-1]};
  assign diff = {1'b0, sh} - {2'b00, dvs_r};
  assign ge   = !diff[prpe_pkg::TIME_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(prpe_pkg::PROD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r <= divisor;
      rem_r <= '0;
      dvd_r <= dividend;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[prpe_pkg::TIME_W-1:0] : sh[prpe_pkg::TIME_W-1:0];
      dvd_r <= {dvd_r[prpe_pkg::PROD_W-2:0], 1'b0};
      q_r   <= {q_r[prpe_pkg::INC_W-2:0], ge};
      ovf_r <= ovf_r | q_r[prpe_pkg::INC_W-1];
    end
  end

  assign done = done_r;
  assign quo  = (ovf_r || (q_r > prpe_pkg::INC_MAX)) ? prpe_pkg::INC_MAX : q_r;

endmodule

[hdl/per_rank_progress_extrapolator.sv]
// Top level: per-rank progress history with two-point linear extrapolation.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------
//   in_     | input     | in_valid/in_stall  | op, rank_index, region_code, time, progress
//   out_    | output    | out_valid/out_stall| rank, progress, has_data, region, last
//   cfg_    | input     | cfg_we             | cfg_index, cfg_wdata
//
// A profile word, unless ignored, reads the history and then writes it back in S_PWR.
// An align word walks the ranks in order. A rank with fewer than two samples,
// a flat or inconsistent slope, full newer or zero older progress goes to S_AOUT;
// one that extrapolates first waits on the 48-step serial multiplier and the
// 65-step serial divider. The block takes a new input word once the last align
// result is in the output register. Reset clears the per-rank valid bits at
// once, so there is no clearing pass. A stalled output holds the walk.
module per_rank_progress_extrapolator #(
  parameter int NUM_RANKS = prpe_pkg::NUM_RANKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_op,
  input  logic [prpe_pkg::RANK_FW-1:0]    in_rank_index,
  input  logic [prpe_pkg::REGION_W-1:0]   in_region_code,
  input  logic [prpe_pkg::TIME_W-1:0]     in_time_ns,
  input  logic [prpe_pkg::PROG_W-1:0]     in_progress_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [prpe_pkg::RANK_FW-1:0]    out_rank,
  output logic [prpe_pkg::PROG_W-1:0]     out_progress_out,
  output logic                            out_has_data,
  output logic [prpe_pkg::REGION_W-1:0]   out_current_region_out,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic [prpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prpe_pkg::REGION_W-1:0]   cfg_wdata
);

  localparam int RANK_W = (NUM_RANKS > 1) ? $clog2(NUM_RANKS) : 1;
  localparam int PW     = prpe_pkg::PROG_W;
  localparam int TW     = prpe_pkg::TIME_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PWR  = 3'd1;
  localparam logic [2:0] S_ARD  = 3'd2;
  localparam logic [2:0] S_AEV  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_AOUT = 3'd6;

  logic [2:0]                      state_r;
  logic [RANK_W-1:0]               rank_r;
  logic [prpe_pkg::REGION_W-1:0]   unmarked_r;
  logic [prpe_pkg::REGION_W-1:0]   epoch_mask_r;
  logic [prpe_pkg::REGION_W-1:0]   region_r;
  logic [TW-1:0]                   time_r;
  logic [PW-1:0]                   prog_r;
  logic [PW-1:0]                   res_r;
  logic                            neg_r;
  logic [TW-1:0]                   adt_r;

  logic                            out_valid_r;
  logic [prpe_pkg::RANK_FW-1:0]    out_rank_r;
  logic [PW-1:0]                   out_prog_r;
  logic                            out_has_r;
  logic [prpe_pkg::REGION_W-1:0]   out_region_r;
  logic                            out_last_r;

  logic                            accept;
  logic                            ignore;
  logic                            hist_re;
  logic                            hist_we;
  logic [RANK_W-1:0]               hist_raddr;
  prpe_pkg::hist_rec_t             rec;
  prpe_pkg::hist_rec_t             wrec;
  logic [1:0]                      cnt0;
  logic [PW:0]                     dp;
  logic [TW:0]                     dt;
  logic [TW:0]                     dd;
  logic [PW-1:0]                   adp;
  logic [TW-1:0]                   adt;
  logic [TW-1:0]                   ad;
  logic                            slope_ok;
  logic                            mul_start;
  logic                            mul_done;
  logic [prpe_pkg::PROD_W-1:0]     prod;
  logic                            div_done;
  logic [prpe_pkg::INC_W-1:0]      inc;
  logic                            out_free;
  logic                            last_rank;

  // Clamp an extrapolated value into 1..65535.
  function automatic logic [PW-1:0] clamp_q16(input logic [PW-1:0] p1,
                                              input logic [prpe_pkg::INC_W-1:0] dlt,
                                              input logic neg);
    logic signed [PW+2:0] s;
    s = neg ? ($signed({3'b000, p1}) - $signed({2'b00, dlt}))
            : ($signed({3'b000, p1}) + $signed({2'b00, dlt}));
    if (s < 1) begin
      return PW'(1);
    end else if (s > $signed({3'b000, prpe_pkg::MAX_Q16})) begin
      return prpe_pkg::MAX_Q16;
    end
    return s[PW-1:0];
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign ignore    = ((in_region_code & epoch_mask_r) != '0)
                  || (in_region_code == unmarked_r)
                  || ({1'b0, in_rank_index} >= (prpe_pkg::RANK_FW + 1)'(NUM_RANKS));
  assign out_free  = !out_valid_r || !out_stall;
  assign last_rank = (rank_r == RANK_W'(NUM_RANKS - 1));

  assign hist_raddr = (state_r == S_IDLE) ? in_rank_index[RANK_W-1:0] : rank_r;
  assign hist_re    = (accept && (in_op == prpe_pkg::OP_PROFILE) && !ignore)
                   || (state_r == S_ARD);
  assign hist_we    = (state_r == S_PWR);

  // Profile update: a new region restarts the history, completion unmarks it.
  always_comb begin
    cnt0          = (region_r != rec.region) ? 2'd0 : rec.cnt;
    wrec.region   = (prog_r == prpe_pkg::ONE_Q16) ? unmarked_r : region_r;
    wrec.t_old    = rec.t_new;
    wrec.p_old    = rec.p_new;
    wrec.t_new    = time_r;
    wrec.p_new    = prog_r;
    wrec.cnt      = (cnt0 == 2'd2) ? 2'd2 : cnt0 + 2'd1;
  end

  // Slope terms of the two stored samples against the align time.
  always_comb begin
    dp       = {1'b0, rec.p_new} - {1'b0, rec.p_old};
    dt       = {1'b0, rec.t_new} - {1'b0, rec.t_old};
    dd       = {1'b0, time_r} - {1'b0, rec.t_new};
    adp      = dp[PW] ? PW'(-dp) : dp[PW-1:0];
    adt      = dt[TW] ? TW'(-dt) : dt[TW-1:0];
    ad       = dd[TW] ? TW'(-dd) : dd[TW-1:0];
    slope_ok = (dp != '0) && (dt != '0) && (dp[PW] == dt[TW]);
  end

  assign mul_start = (state_r == S_AEV) && (rec.cnt == 2'd2)
                  && (rec.p_new != prpe_pkg::ONE_Q16) && (rec.p_old != '0) && slope_ok;

  prpe_hist #(
    .DEPTH (NUM_RANKS),
    .AW    (RANK_W)
  ) u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (hist_we),
    .waddr (rank_r),
    .wdata (wrec),
    .re    (hist_re),
    .raddr (hist_raddr),
    .rdata (rec)
  );

  prpe_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (adp),
    .b     (ad),
    .done  (mul_done),
    .prod  (prod)
  );

  prpe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mul_done),
    .dividend (prod),
    .divisor  (adt_r),
    .done     (div_done),
    .quo      (inc)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unmarked_r   <= '0;
      epoch_mask_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        prpe_pkg::REG_UNMARKED: unmarked_r   <= cfg_wdata;
        prpe_pkg::REG_EPOCH:    epoch_mask_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rank_r  <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_op == prpe_pkg::OP_ALIGN) begin
              rank_r  <= '0;
              state_r <= S_ARD;
            end else if (!ignore) begin
              rank_r  <= in_rank_index[RANK_W-1:0];
              state_r <= S_PWR;
            end
          end
        end
        S_PWR:  state_r <= S_IDLE;
        S_ARD:  state_r <= S_AEV;
        S_AEV:  state_r <= mul_start ? S_MUL : S_AOUT;
        S_MUL:  if (mul_done) state_r <= S_DIV;
        S_DIV:  if (div_done) state_r <= S_AOUT;
        S_AOUT: begin
          if (out_free) begin
            if (last_rank) begin
              state_r <= S_IDLE;
            end else begin
              rank_r  <= rank_r + 1'b1;
              state_r <= S_ARD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Item and result datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      region_r <= in_region_code;
      time_r   <= in_time_ns;
      prog_r   <= (in_progress_in > prpe_pkg::ONE_Q16) ? prpe_pkg::ONE_Q16
                                                        : in_progress_in;
    end
    if (state_r == S_AEV) begin
      neg_r <= dd[TW];
      adt_r <= adt;
      if (rec.cnt == 2'd0) begin
        res_r <= '0;
      end else if (rec.cnt == 2'd1) begin
        res_r <= rec.p_new;
      end else if (rec.p_new == prpe_pkg::ONE_Q16) begin
        res_r <= prpe_pkg::ONE_Q16;
      end else if (rec.p_old == '0) begin
        res_r <= '0;
      end else begin
        res_r <= clamp_q16(rec.p_new, '0, 1'b0);
      end
    end
    if ((state_r == S_DIV) && div_done) begin
      res_r <= clamp_q16(rec.p_new, inc, neg_r);
    end
  end

  // Output register: parts the walk from the downstream stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_AOUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_AOUT) && out_free) begin
      out_rank_r   <= prpe_pkg::RANK_FW'(rank_r);
      out_prog_r   <= res_r;
      out_has_r    <= (rec.cnt != 2'd0);
      out_region_r <= rec.region;
      out_last_r   <= last_rank;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_rank               = out_rank_r;
  assign out_progress_out       = out_prog_r;
  assign out_has_data           = out_has_r;
  assign out_current_region_out = out_region_r;
  assign out_last               = out_last_r;

  // A rank without samples never reports progress.
  a_nodata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_data) |-> (out_progress_out == '0))
    else $error("progress reported for a rank without samples");

  // The last flag rides only on the final rank.
  a_last_rank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_rank == prpe_pkg::RANK_FW'(NUM_RANKS - 1)))
    else $error("last flag on a rank other than the final one");

  // Reported progress never exceeds complete.
  a_prog_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_progress_out <= prpe_pkg::ONE_Q16))
    else $error("progress above complete");

  // The divider only finishes while the sequencer waits for it.
  a_div_sync: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider result outside its wait state");

endmodule
